@@ rtl/aaids_pkg.sv @@
package aaids_pkg;

  localparam int SAMPLE_W = 8;
  localparam int AVG_W    = 16;
  localparam int FRAC_W   = 8;
  localparam int POS_W    = 11;
  localparam int REG_W    = 12;
  localparam int CHAN_W   = 3;
  localparam int IDX_W    = 3;
  localparam int LANES    = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_CHAN_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
  } in_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg_a;
    logic [AVG_W-1:0] avg_b;
    logic [AVG_W-1:0] avg_c;
    logic [AVG_W-1:0] avg_d;
    logic [POS_W-1:0] dst_col;
    logic [POS_W-1:0] dst_row;
    logic             frame_end;
  } out_t;

  // lane control, driven by the sequencer in the top level
  typedef struct packed {
    logic load;     // item accepted this cycle
    logic clr;      // clear the horizontal partial sum
    logic colfin;   // this item completes an output column
    logic row_end;  // this item ends an input row
    logic mac;      // vertical accumulate and line write
    logic div;      // one divider step
    logic rsplit;   // the column completes an output row
    logic seen;     // line entry holds data of this frame
  } lane_ctl_t;

endpackage

@@ rtl/aaids_in_if.sv @@
interface aaids_in_if import aaids_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/aaids_out_if.sv @@
interface aaids_out_if import aaids_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/aaids_lane.sv @@
module aaids_lane import aaids_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  lane_ctl_t                           ctl,
  input  logic [SAMPLE_W-1:0]                 v,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      take,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      rest,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      ow,
  input  logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     wy1,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     wy2,
  input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] area,
  output logic [AVG_W-1:0]                    q
);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int PW = SAMPLE_W + WW;
  localparam int AW = PW + HW;
  localparam int RW = AW + FRAC_W;

  logic [PW-1:0] hp;
  logic [PW-1:0] h;
  logic [AW-1:0] line_mem [MAX_WIDTH];
  logic [AW-1:0] rdata;
  logic [AW-1:0] acc;
  logic [AW-1:0] wdata;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;

  assign acc   = (ctl.seen ? rdata : '0) + AW'(h) * AW'(wy1);
  assign wdata = ctl.rsplit ? AW'(h) * AW'(wy2) : acc;

  // horizontal partial sum
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      hp <= '0;
    end else if (ctl.load) begin
      if (ctl.colfin) begin
        h  <= hp + PW'(v) * PW'(take);
        hp <= ctl.row_end ? '0 : PW'(v) * PW'(rest);
      end else begin
        hp <= ctl.row_end ? '0 : hp + PW'(v) * PW'(ow);
      end
    end
  end

  // column accumulator line
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rdata <= line_mem[rd_addr];
    end
    if (ctl.mac) begin
      line_mem[wr_addr] <= wdata;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.mac) begin
      rem <= {acc, {FRAC_W{1'b0}}};
      dvs <= RW'(area) << (AVG_W-1);
      q   <= '0;
    end else if (ctl.div) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        q   <= {q[AVG_W-2:0], 1'b1};
      end else begin
        q   <= {q[AVG_W-2:0], 1'b0};
      end
      dvs <= dvs >> 1;
    end
  end

endmodule

@@ rtl/area_average_image_downscale.sv @@
// Sequence: an item inside an output column is taken in S_IDLE alone, an item that
// closes a column without closing a row passes S_MAC, and an item that completes
// an output pixel passes S_MAC (accumulate), 16 steps of the per-lane divider
// (S_DIV) and S_OUT (merge) to a registered result; the merge holds while the last
// result waits. Throughput: one item at a time; the divider sets the worst case.
// Reset (synchronous, active high) sets every configuration register to 1 and
// restarts the frame; no clearing pass is needed, the first input row ignores the line.
module area_average_image_downscale import aaids_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_HEIGHT   = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_idx,
  input  logic [REG_W-1:0]  cfg_data,
  aaids_in_if.sink          in_ch,
  aaids_out_if.source       out_ch
);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(AVG_W);

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DIV, S_OUT} state_t;

  state_t state;

  // raw register values
  logic [REG_W-1:0]  src_width, src_height, dst_width, dst_height;
  logic [CHAN_W-1:0] chan_count;

  // saturated sizes
  logic [WW-1:0]     iw, ow;
  logic [HW-1:0]     ih, oh;
  logic [CHAN_W-1:0] nc;
  logic [WW+HW-1:0]  area;

  // stream position; rooms are kept as units used so a restart needs no sizes
  logic [XW-1:0] src_col_pos, dst_col_pos;
  logic [YW-1:0] src_row_pos, dst_row_pos;
  logic [WW-1:0] col_used;
  logic [HW-1:0] row_used;

  logic [WW-1:0] col_room, rest;
  logic [HW-1:0] row_room, wy1, wy2;
  logic          colfin, rsplit, row_end, frame_wrap, accept, cfg_hit;

  // item held for the accumulate and divide steps
  logic [XW-1:0]  x_q;
  logic [YW-1:0]  row_q;
  logic [HW-1:0]  wy1_q, wy2_q;
  logic           rsplit_q, seen_q, fe_q;
  logic [CW-1:0]  cnt;

  logic [SAMPLE_W-1:0] smp [LANES];
  logic [SAMPLE_W-1:0] v   [LANES];
  logic [AVG_W-1:0]    qs  [LANES];
  lane_ctl_t           ctl;

  logic out_valid;
  out_t out_q;

  // saturate the registers
  always_comb begin
    if (src_width == '0) iw = WW'(1);
    else if (32'(src_width) > 32'(MAX_WIDTH)) iw = WW'(MAX_WIDTH);
    else iw = WW'(src_width);
    if (src_height == '0) ih = HW'(1);
    else if (32'(src_height) > 32'(MAX_HEIGHT)) ih = HW'(MAX_HEIGHT);
    else ih = HW'(src_height);
    if (dst_width == '0) ow = WW'(1);
    else if (32'(dst_width) > 32'(iw)) ow = iw;
    else ow = WW'(dst_width);
    if (dst_height == '0) oh = HW'(1);
    else if (32'(dst_height) > 32'(ih)) oh = ih;
    else oh = HW'(dst_height);
    if (chan_count == '0) nc = CHAN_W'(1);
    else if (32'(chan_count) > 32'(MAX_CHANNELS)) nc = CHAN_W'(MAX_CHANNELS);
    else nc = chan_count;
  end

  // per-item weights: horizontal split of the column, vertical split of the row
  assign col_room   = iw - col_used;
  assign row_room   = ih - row_used;
  assign colfin     = !(ow < col_room);
  assign rest       = ow - col_room;
  assign rsplit     = (oh >= row_room);
  assign wy1        = rsplit ? row_room : oh;
  assign wy2        = rsplit ? oh - row_room : '0;
  assign row_end    = (WW'(src_col_pos) + WW'(1) >= iw);
  assign frame_wrap = row_end && (HW'(src_row_pos) + HW'(1) >= ih);

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_hit     = cfg_we && (cfg_idx <= REG_CHAN_COUNT);

  assign smp[0] = in_ch.data.sample_a;
  assign smp[1] = in_ch.data.sample_b;
  assign smp[2] = in_ch.data.sample_c;
  assign smp[3] = in_ch.data.sample_d;

  // drop channels beyond the configured count
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      v[c] = (CHAN_W'(c) < nc) ? smp[c] : '0;
    end
  end

  always_comb begin
    ctl.load    = accept;
    ctl.clr     = rst || cfg_hit;
    ctl.colfin  = colfin;
    ctl.row_end = row_end;
    ctl.mac     = (state == S_MAC);
    ctl.div     = (state == S_DIV);
    ctl.rsplit  = rsplit_q;
    ctl.seen    = seen_q;
  end

  always_ff @(posedge clk) begin
    area <= WW'(iw) * (WW+HW)'(ih);
  end

  // one lane per channel, each with its line memory and divider
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_on
      aaids_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_lane (
        .clk     (clk),
        .ctl     (ctl),
        .v       (v[c]),
        .take    (col_room),
        .rest    (rest),
        .ow      (ow),
        .rd_addr (dst_col_pos),
        .wr_addr (x_q),
        .wy1     (wy1_q),
        .wy2     (wy2_q),
        .area    (area),
        .q       (qs[c])
      );
    end else begin : g_off
      assign qs[c] = '0;
    end
  end

  // sequencer, stream position and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      src_width   <= REG_W'(1);
      src_height  <= REG_W'(1);
      dst_width   <= REG_W'(1);
      dst_height  <= REG_W'(1);
      chan_count  <= CHAN_W'(1);
      src_col_pos <= '0;
      src_row_pos <= '0;
      dst_col_pos <= '0;
      dst_row_pos <= '0;
      col_used    <= '0;
      row_used    <= '0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      // load the result register from the merge, or drop the item once taken
      if (state == S_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_hit) begin
        case (cfg_idx)
          REG_SRC_WIDTH:  src_width  <= cfg_data;
          REG_SRC_HEIGHT: src_height <= cfg_data;
          REG_DST_WIDTH:  dst_width  <= cfg_data;
          REG_DST_HEIGHT: dst_height <= cfg_data;
          REG_CHAN_COUNT: chan_count <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
        // restart the frame
        src_col_pos <= '0;
        src_row_pos <= '0;
        dst_col_pos <= '0;
        dst_row_pos <= '0;
        col_used    <= '0;
        row_used    <= '0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            x_q      <= dst_col_pos;
            row_q    <= dst_row_pos;
            wy1_q    <= wy1;
            wy2_q    <= wy2;
            rsplit_q <= rsplit;
            seen_q   <= (src_row_pos != '0);
            fe_q     <= (WW'(dst_col_pos) + WW'(1) == ow) &&
                        (HW'(dst_row_pos) + HW'(1) == oh);
            if (colfin) begin
              state <= S_MAC;
            end
            if (row_end) begin
              src_col_pos <= '0;
              dst_col_pos <= '0;
              col_used    <= '0;
              if (frame_wrap) begin
                src_row_pos <= '0;
                dst_row_pos <= '0;
                row_used    <= '0;
              end else begin
                src_row_pos <= src_row_pos + 1'b1;
                if (rsplit) begin
                  row_used    <= wy2;
                  dst_row_pos <= (HW'(dst_row_pos) + HW'(1) >= oh) ? '0
                                                                   : dst_row_pos + 1'b1;
                end else begin
                  row_used <= row_used + oh;
                end
              end
            end else begin
              src_col_pos <= src_col_pos + 1'b1;
              if (colfin) begin
                col_used    <= rest;
                dst_col_pos <= (WW'(dst_col_pos) + WW'(1) >= ow) ? '0
                                                                  : dst_col_pos + 1'b1;
              end else begin
                col_used <= col_used + ow;
              end
            end
          end
        end
        S_MAC: begin
          cnt   <= '0;
          state <= rsplit_q ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(AVG_W-1)) state <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register is free, then merge the lanes
          if (!out_valid || out_ch.ready) begin
            out_q.avg_a     <= (CHAN_W'(0) < nc) ? qs[0] : '0;
            out_q.avg_b     <= (CHAN_W'(1) < nc) ? qs[1] : '0;
            out_q.avg_c     <= (CHAN_W'(2) < nc) ? qs[2] : '0;
            out_q.avg_d     <= (CHAN_W'(3) < nc) ? qs[3] : '0;
            out_q.dst_col   <= POS_W'(x_q);
            out_q.dst_row   <= POS_W'(row_q);
            out_q.frame_end <= fe_q;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

endmodule
